// ----- hdl/ncis_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ncis_pkg;

  // Field widths.
  localparam int CoordW  = 12;
  localparam int PtW     = 16;
  localparam int ChargeW = 2;
  localparam int SumW    = 24;
  localparam int RadW    = 24;

  // Internal widths: a coordinate difference needs one more bit than a
  // coordinate. |deta| reaches 4095, a wrapped |dphi| stays within 1608.
  localparam int DiffW    = CoordW + 1;
  localparam int EtaAbsW  = CoordW;
  localparam int PhiAbsW  = 11;
  localparam int EtaSqW   = 2 * EtaAbsW;
  localparam int PhiSqW   = 2 * PhiAbsW;
  localparam int Dr2W     = EtaSqW + 1;

  // Azimuth wrap constants, LSB 2^-9: pi is 1608.5, two pi is 3217.
  localparam logic signed [DiffW-1:0] PiHiQ  = 13'sd1608;
  localparam logic signed [DiffW-1:0] TwoPiQ = 13'sd3217;

  localparam logic [SumW-1:0] SumMax        = {SumW{1'b1}};
  localparam logic [RadW-1:0] OuterRadReset = 24'd262144;
  localparam logic [RadW-1:0] InnerRadReset = 24'd0;

  localparam int CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OUTER_RADIUS_SQ = 1'b0,
    CFG_INNER_RADIUS_SQ = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [RadW-1:0] outer_sq;
    logic [RadW-1:0] inner_sq;
  } radius_cfg_t;

  // One beat between the distance stage and the accumulate stage.
  typedef struct packed {
    logic [EtaSqW-1:0] eta_sq;
    logic [PhiSqW-1:0] phi_sq;
    logic [PtW-1:0]    pt;
    logic              neutral;
    logic              last;
  } sq_beat_t;

endpackage

`default_nettype wire

// ----- hdl/neutral_cone_isolation_sum.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Neutral cone isolation sum. Each input beat pairs a reference track
// position with one candidate; a stream of candidates for one track ends with
// the beat that has last_cand_i set, and that beat yields one result beat
// holding the summed pt of all neutral candidates (charge zero) whose squared
// distance dR2 = deta^2 + dphi^2 (dphi wrapped into [-pi, pi)) lies in
// [inner_radius_sq, outer_radius_sq). The sum saturates at its maximum and
// saturated_o reports it. The block takes one candidate every clock cycle;
// that rate is set by the single accumulator register, which absorbs one
// candidate per cycle. The final candidate passes in order through the input
// register, the squares register and the annulus-test register, after which
// the accumulate step loads the result register with the finished sum.
// Candidates that are not final keep flowing while a result waits to be
// taken; only the next final candidate waits for the result register.
// Configuration is taken every cycle (cfg_ready_o is always high) and must be
// written only while no candidate is in flight.
module neutral_cone_isolation_sum
  import ncis_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Candidate channel.
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [CoordW-1:0]  ref_eta_i,
  input  wire logic signed [CoordW-1:0]  ref_phi_i,
  input  wire logic signed [CoordW-1:0]  cand_eta_i,
  input  wire logic signed [CoordW-1:0]  cand_phi_i,
  input  wire logic [PtW-1:0]            cand_pt_i,
  input  wire logic signed [ChargeW-1:0] cand_charge_i,
  input  wire logic                      last_cand_i,
  // Result channel.
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [SumW-1:0]                iso_sum_o,
  output logic                           saturated_o,
  // Configuration write channel.
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [RadW-1:0]           cfg_data_i
);

  radius_cfg_t cfg_q;
  logic        sq_valid;
  logic        sq_ready;
  sq_beat_t    sq_beat;

  // The register file never stalls a write beat.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.outer_sq <= OuterRadReset;
      cfg_q.inner_sq <= InnerRadReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OUTER_RADIUS_SQ: cfg_q.outer_sq <= cfg_data_i;
        CFG_INNER_RADIUS_SQ: cfg_q.inner_sq <= cfg_data_i;
      endcase
    end
  end

  // Front end: input register and the two squares, registered.
  ncis_dist u_dist (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ref_eta_i     (ref_eta_i),
    .ref_phi_i     (ref_phi_i),
    .cand_eta_i    (cand_eta_i),
    .cand_phi_i    (cand_phi_i),
    .cand_pt_i     (cand_pt_i),
    .cand_charge_i (cand_charge_i),
    .last_cand_i   (last_cand_i),
    .sq_valid_o    (sq_valid),
    .sq_ready_i    (sq_ready),
    .sq_o          (sq_beat)
  );

  // Back end: annulus test, saturating accumulator and result register.
  ncis_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .sq_valid_i  (sq_valid),
    .sq_ready_o  (sq_ready),
    .sq_i        (sq_beat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .iso_sum_o   (iso_sum_o),
    .saturated_o (saturated_o)
  );

endmodule

`default_nettype wire

// ----- hdl/ncis_dist.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input register, delta-eta and wrapped delta-phi, and the two squares.
module ncis_dist
  import ncis_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [CoordW-1:0]  ref_eta_i,
  input  wire logic signed [CoordW-1:0]  ref_phi_i,
  input  wire logic signed [CoordW-1:0]  cand_eta_i,
  input  wire logic signed [CoordW-1:0]  cand_phi_i,
  input  wire logic [PtW-1:0]            cand_pt_i,
  input  wire logic signed [ChargeW-1:0] cand_charge_i,
  input  wire logic                      last_cand_i,
  output logic                           sq_valid_o,
  input  wire logic                      sq_ready_i,
  output sq_beat_t                       sq_o
);

  logic                      a_valid_q;
  logic signed [CoordW-1:0]  a_ref_eta_q, a_ref_phi_q, a_cand_eta_q, a_cand_phi_q;
  logic [PtW-1:0]            a_pt_q;
  logic                      a_neutral_q;
  logic                      a_last_q;
  logic                      a_ready;

  logic                      b_valid_q;
  sq_beat_t                  b_q, b_d;
  logic                      b_ready;

  logic signed [DiffW-1:0]   deta, dphi_raw, dphi;
  logic [EtaAbsW-1:0]        deta_abs;
  logic [PhiAbsW-1:0]        dphi_abs;

  assign b_ready    = !b_valid_q || sq_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_ref_eta_q  <= ref_eta_i;
      a_ref_phi_q  <= ref_phi_i;
      a_cand_eta_q <= cand_eta_i;
      a_cand_phi_q <= cand_phi_i;
      a_pt_q       <= cand_pt_i;
      a_neutral_q  <= (cand_charge_i == '0);
      a_last_q     <= last_cand_i;
    end
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  always_comb begin
    deta     = {a_cand_eta_q[CoordW-1], a_cand_eta_q} - {a_ref_eta_q[CoordW-1], a_ref_eta_q};
    dphi_raw = {a_cand_phi_q[CoordW-1], a_cand_phi_q} - {a_ref_phi_q[CoordW-1], a_ref_phi_q};
    // One wrap step always lands inside [-pi, pi) for any 12-bit inputs.
    if (dphi_raw > PiHiQ) begin
      dphi = dphi_raw - TwoPiQ;
    end else if (dphi_raw < -PiHiQ) begin
      dphi = dphi_raw + TwoPiQ;
    end else begin
      dphi = dphi_raw;
    end
    deta_abs = deta[DiffW-1] ? EtaAbsW'(-deta) : EtaAbsW'(deta);
    dphi_abs = dphi[DiffW-1] ? PhiAbsW'(-dphi) : PhiAbsW'(dphi);

    b_d.eta_sq  = EtaSqW'(deta_abs) * EtaSqW'(deta_abs);
    b_d.phi_sq  = PhiSqW'(dphi_abs) * PhiSqW'(dphi_abs);
    b_d.pt      = a_pt_q;
    b_d.neutral = a_neutral_q;
    b_d.last    = a_last_q;
  end

  assign sq_valid_o = b_valid_q;
  assign sq_o       = b_q;

endmodule

`default_nettype wire

// ----- hdl/ncis_accum.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Annulus test, saturating pt accumulator and the result register.
module ncis_accum
  import ncis_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire radius_cfg_t cfg_i,
  input  wire logic        sq_valid_i,
  output logic             sq_ready_o,
  input  wire sq_beat_t    sq_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [SumW-1:0]  iso_sum_o,
  output logic             saturated_o
);

  logic            c_valid_q;
  logic            c_hit_q;
  logic [PtW-1:0]  c_pt_q;
  logic            c_last_q;
  logic            c_ready;
  logic            c_fire;

  logic [Dr2W-1:0] dr2;
  logic            hit_d;

  logic [SumW-1:0] acc_q, acc_d;
  logic            sat_q, sat_d;
  logic [SumW:0]   sum_wide;

  logic            out_valid_q;
  logic [SumW-1:0] out_sum_q;
  logic            out_sat_q;

  // A non-final candidate always drains into the accumulator; only the
  // final one waits for room in the result register.
  assign c_fire     = c_valid_q && (!c_last_q || !out_valid_q || out_ready_i);
  assign c_ready    = !c_valid_q || c_fire;
  assign sq_ready_o = c_ready;

  always_comb begin
    dr2   = {1'b0, sq_i.eta_sq} + Dr2W'(sq_i.phi_sq);
    hit_d = sq_i.neutral && (dr2 < Dr2W'(cfg_i.outer_sq)) && (dr2 >= Dr2W'(cfg_i.inner_sq));
  end

  always_comb begin
    sum_wide = {1'b0, acc_q} + (SumW + 1)'(c_pt_q);
    acc_d    = acc_q;
    sat_d    = sat_q;
    if (c_hit_q) begin
      if (sum_wide >= {1'b0, SumMax}) begin
        acc_d = SumMax;
        sat_d = 1'b1;
      end else begin
        acc_d = sum_wide[SumW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      acc_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= sq_valid_i;
      end
      if (c_fire) begin
        if (c_last_q) begin
          acc_q <= '0;
          sat_q <= 1'b0;
        end else begin
          acc_q <= acc_d;
          sat_q <= sat_d;
        end
      end
      if (c_fire && c_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && sq_valid_i) begin
      c_hit_q  <= hit_d;
      c_pt_q   <= sq_i.pt;
      c_last_q <= sq_i.last;
    end
    if (c_fire && c_last_q) begin
      out_sum_q <= acc_d;
      out_sat_q <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign iso_sum_o   = out_sum_q;
  assign saturated_o = out_sat_q;

`ifndef SYNTHESIS
  a_sat_means_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (acc_q == SumMax))
    else $error("saturation flag set while accumulator is below its maximum");

  a_out_sat_means_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |-> (out_sum_q == SumMax))
    else $error("saturated result carries a sum below the maximum");

  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_fire && c_last_q) |=> ((acc_q == '0) && !sat_q))
    else $error("accumulator not cleared after the final candidate");

  a_no_result_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(c_fire && c_last_q))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ----- tb/neutral_cone_isolation_sum_test.sv -----
`timescale 1ns / 1ps

module neutral_cone_isolation_sum_test;
  import ncis_pkg::*;

  // Charge patterns on the two-bit charge field. Only the neutral pattern is
  // summed; the odd pattern is nonzero and so counts as charged.
  localparam logic signed [ChargeW-1:0] ChargeNeutral = 2'sb00;
  localparam logic signed [ChargeW-1:0] ChargePos     = 2'sb01;
  localparam logic signed [ChargeW-1:0] ChargeNeg     = 2'sb11;
  localparam logic signed [ChargeW-1:0] ChargeOdd     = 2'sb10;

  localparam logic [RadW-1:0] RadMax = {RadW{1'b1}};
  localparam int PhiLow  = -1609;
  localparam int PhiHigh = 1608;
  localparam int PhaseBeats = 100;
  localparam int DrainCycles = 8;

  typedef struct {
    logic signed [CoordW-1:0]  trk_eta;
    logic signed [CoordW-1:0]  trk_phi;
    logic signed [CoordW-1:0]  eta;
    logic signed [CoordW-1:0]  phi;
    logic [PtW-1:0]            pt;
    logic signed [ChargeW-1:0] charge;
    logic                      last;
  } cand_t;

  typedef struct {
    logic [SumW-1:0] sum;
    logic            sat;
  } iso_result_t;

  // Tracks the annulus sum of the track in progress and holds the sums that
  // the block still owes, oldest first.
  class cone_sum_tracker;
    logic [RadW-1:0] outer_sq;
    logic [RadW-1:0] inner_sq;
    logic [SumW-1:0] acc;
    logic            sat;
    iso_result_t     expected_sums[$];
    int              mismatches;
    int              checked;
    int              saturated_seen;
    int              tracks;

    function new();
      outer_sq = OuterRadReset;
      inner_sq = InnerRadReset;
      acc = '0;
      sat = 1'b0;
      mismatches = 0;
      checked = 0;
      saturated_seen = 0;
      tracks = 0;
    endfunction

    function void set_radius(cfg_idx_e idx, logic [RadW-1:0] value);
      case (idx)
        CFG_OUTER_RADIUS_SQ: outer_sq = value;
        CFG_INNER_RADIUS_SQ: inner_sq = value;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return expected_sums.size();
    endfunction

    function void note_candidate(cand_t c);
      int deta;
      int dphi;
      int unsigned dr2;
      int unsigned total;
      iso_result_t r;
      if (c.charge == ChargeNeutral) begin
        deta = int'(c.eta) - int'(c.trk_eta);
        dphi = int'(c.phi) - int'(c.trk_phi);
        // One wrap step brings any 12-bit difference back into [-pi, pi).
        if (dphi > int'(PiHiQ)) begin
          dphi = dphi - int'(TwoPiQ);
        end else if (dphi < -int'(PiHiQ)) begin
          dphi = dphi + int'(TwoPiQ);
        end
        dr2 = deta * deta + dphi * dphi;
        if (dr2 < outer_sq && dr2 >= inner_sq) begin
          total = acc + c.pt;
          if (total >= SumMax) begin
            total = SumMax;
            sat = 1'b1;
          end
          acc = total[SumW-1:0];
        end
      end
      if (c.last) begin
        r.sum = acc;
        r.sat = sat;
        expected_sums = {expected_sums, r};
        acc = '0;
        sat = 1'b0;
        tracks++;
      end
    endfunction

    function void check_sum(logic [SumW-1:0] sum, logic sat_bit);
      iso_result_t e;
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected result beat sum=%0d saturated=%0b", sum, sat_bit);
        end
      end else begin
        e = expected_sums.pop_front();
        checked++;
        if (e.sat) begin
          saturated_seen++;
        end
        if (sum !== e.sum || sat_bit !== e.sat) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"ERROR: sum %0d: expected iso_sum=%0d saturated=%0b, ",
                      "got iso_sum=%0d saturated=%0b"},
                     checked, e.sum, e.sat, sum, sat_bit);
          end
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  logic                      in_valid;
  logic                      in_ready;
  logic signed [CoordW-1:0]  trk_eta;
  logic signed [CoordW-1:0]  trk_phi;
  logic signed [CoordW-1:0]  cand_eta;
  logic signed [CoordW-1:0]  cand_phi;
  logic [PtW-1:0]            cand_pt;
  logic signed [ChargeW-1:0] cand_charge;
  logic                      last_cand;

  logic            out_valid;
  logic            out_ready;
  logic [SumW-1:0] iso_sum;
  logic            saturated;

  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [RadW-1:0]    cfg_data;

  cone_sum_tracker tracker;

  // Percent of cycles in which each side idles, and the length of a forced
  // receiver hold-off that is still to run.
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int beats_sent;
  int radius_writes;

  neutral_cone_isolation_sum u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .ref_eta_i     (trk_eta),
    .ref_phi_i     (trk_phi),
    .cand_eta_i    (cand_eta),
    .cand_phi_i    (cand_phi),
    .cand_pt_i     (cand_pt),
    .cand_charge_i (cand_charge),
    .last_cand_i   (last_cand),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .iso_sum_o     (iso_sum),
    .saturated_o   (saturated),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The whole run is bounded by a fixed time well beyond the slowest
  // legal run, so a hung handshake ends the simulation.
  initial begin
    #2_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("Simulation FAILED");
    $finish;
  end

  // Result side. The ready decision is made at the falling edge; a pending
  // hold-off overrides the random stalls until its cycle count runs out.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every result beat is checked against the oldest sum still owed. The
  // handshake is sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_sum(iso_sum, saturated);
    end
  end

  // Offers one candidate beat, with random idle cycles in front of it, and
  // holds it until the block takes it. Valid is left high on return so that
  // a following beat goes out back to back.
  task automatic send_candidate(cand_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    trk_eta     = c.trk_eta;
    trk_phi     = c.trk_phi;
    cand_eta    = c.eta;
    cand_phi    = c.phi;
    cand_pt     = c.pt;
    cand_charge = c.charge;
    last_cand   = c.last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    tracker.note_candidate(c);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic write_radius(cfg_idx_e idx, logic [RadW-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    tracker.set_radius(idx, value);
    radius_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // The sender stops until every owed sum has come back, then a few more
  // cycles pass so that no candidate is left in the pipeline.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (tracker.outstanding() > 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic cand_t make_cand(int te, int tp, int ce, int cp, int pt,
                                      logic signed [ChargeW-1:0] q, logic last);
    cand_t c;
    c.trk_eta = CoordW'(te);
    c.trk_phi = CoordW'(tp);
    c.eta     = CoordW'(ce);
    c.phi     = CoordW'(cp);
    c.pt      = PtW'(pt);
    c.charge  = q;
    c.last    = last;
    return c;
  endfunction

  // Azimuth for a random position: mostly within [PhiLow, PhiHigh], sometimes any
  // 12-bit pattern, which the single wrap step must also handle.
  function automatic int random_phi();
    if ($urandom_range(99) < 10) begin
      return int'($urandom_range(4095)) - 2048;
    end
    return int'($urandom_range(PhiHigh - PhiLow)) + PhiLow;
  endfunction

  function automatic cand_t random_cand(int te, int tp, int near_pct, logic last);
    cand_t c;
    int ce;
    int cp;
    if ($urandom_range(99) < near_pct) begin
      // Close to the track, folded back into range so that pairs straddling
      // the phi seam go through the wrap.
      ce = te + int'($urandom_range(1200)) - 600;
      cp = tp + int'($urandom_range(1200)) - 600;
      if (cp > PhiHigh) begin
        cp = cp - int'(TwoPiQ);
      end else if (cp < PhiLow) begin
        cp = cp + int'(TwoPiQ);
      end
    end else begin
      ce = int'($urandom_range(4095)) - 2048;
      cp = random_phi();
    end
    c = make_cand(te, tp, ce, cp, 0, ChargeNeutral, last);
    case ($urandom_range(15))
      0: c.pt = '1;
      1: c.pt = '0;
      default: c.pt = PtW'($urandom);
    endcase
    if ($urandom_range(99) >= 60) begin
      case ($urandom_range(2))
        0: c.charge = ChargePos;
        1: c.charge = ChargeNeg;
        default: c.charge = ChargeOdd;
      endcase
    end
    return c;
  endfunction

  // One well-formed track: a fixed reference position and a run of
  // candidates whose final beat carries the last flag.
  task automatic run_track(int len, int near_pct);
    int te;
    int tp;
    te = int'($urandom_range(4095)) - 2048;
    tp = random_phi();
    for (int k = 0; k < len; k++) begin
      send_candidate(random_cand(te, tp, near_pct, k == len - 1));
    end
  endtask

  function automatic int random_track_len();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(9, 24);
    end
    return $urandom_range(1, 8);
  endfunction

  initial begin
    int phase_start;
    logic [RadW-1:0] outer_v;
    logic [RadW-1:0] inner_v;
    int guard;

    tracker       = new();
    send_idle_pct = 9;
    recv_idle_pct = 75;
    hold_left     = 0;
    beats_sent    = 0;
    radius_writes = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    trk_eta     = '0;
    trk_phi     = '0;
    cand_eta    = '0;
    cand_phi    = '0;
    cand_pt     = '0;
    cand_charge = ChargeNeutral;
    last_cand   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_OUTER_RADIUS_SQ;
    cfg_data    = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part with the reset radii: full pt at zero distance, all
    // three charged patterns skipped, the phi wrap in both directions, the
    // far corner in eta, and the exclusive outer bound just hit and missed.
    send_candidate(make_cand(0, 0, 0, 0, 65535, ChargeNeutral, 1'b0));
    send_candidate(make_cand(0, 0, 0, 0, 1000, ChargePos, 1'b0));
    send_candidate(make_cand(0, 0, 0, 0, 1000, ChargeNeg, 1'b0));
    send_candidate(make_cand(0, 0, 0, 0, 1000, ChargeOdd, 1'b0));
    send_candidate(make_cand(0, PhiLow, 0, PhiHigh, 7, ChargeNeutral, 1'b0));
    send_candidate(make_cand(0, PhiHigh, 0, PhiLow, 9, ChargeNeutral, 1'b0));
    send_candidate(make_cand(-2048, 0, 2047, 0, 100, ChargeNeutral, 1'b0));
    send_candidate(make_cand(0, 0, 512, 0, 3, ChargeNeutral, 1'b0));
    send_candidate(make_cand(0, 0, 511, 0, 5, ChargeNeutral, 1'b1));
    // A track of one charged candidate, and one of a neutral with zero pt.
    send_candidate(make_cand(100, 100, 100, 100, 500, ChargePos, 1'b1));
    send_candidate(make_cand(100, 100, 100, 100, 0, ChargeNeutral, 1'b1));
    send_candidate(make_cand(-2048, PhiLow, -2048, PhiLow, 1, ChargeNeutral, 1'b0));
    send_candidate(make_cand(2047, PhiHigh, 2047, PhiHigh, 2, ChargeNeutral, 1'b1));
    wait_idle();

    // Inclusive inner bound: exactly on it is summed, one step inside is
    // not. The widest outer bound still admits the far eta corner.
    write_radius(CFG_OUTER_RADIUS_SQ, RadMax);
    write_radius(CFG_INNER_RADIUS_SQ, 24'd1024);
    send_candidate(make_cand(0, 0, 32, 0, 11, ChargeNeutral, 1'b0));
    send_candidate(make_cand(0, 0, 31, 0, 13, ChargeNeutral, 1'b0));
    send_candidate(make_cand(0, 1590, 0, -1595, 17, ChargeNeutral, 1'b0));
    send_candidate(make_cand(2047, 0, -2048, 0, 19, ChargeNeutral, 1'b1));
    wait_idle();

    // Random part, in phases with their own radii and idle pattern. The
    // sender stops at each phase end until all sums are back, so the
    // radii only change while the block is empty.
    for (int p = 0; p < 7; p++) begin
      if (p < 2) begin
        send_idle_pct = 9;
        recv_idle_pct = 75;
      end else if (p < 4) begin
        send_idle_pct = 75;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: begin
          outer_v = OuterRadReset;
          inner_v = InnerRadReset;
        end
        1: begin
          outer_v = RadMax;
          inner_v = '0;
        end
        2: begin
          outer_v = '0;
          inner_v = '0;
        end
        3: begin
          // Inner bound equal to the outer one leaves an empty annulus.
          outer_v = RadMax;
          inner_v = RadMax;
        end
        4: begin
          outer_v = 24'd500000;
          inner_v = 24'd40000;
        end
        5: begin
          outer_v = RadW'($urandom_range(RadMax));
          inner_v = RadW'($urandom_range(outer_v));
        end
        default: begin
          outer_v = RadW'($urandom_range(1 << 20));
          inner_v = outer_v + RadW'(1 + $urandom_range(4096));
        end
      endcase
      write_radius(CFG_OUTER_RADIUS_SQ, outer_v);
      write_radius(CFG_INNER_RADIUS_SQ, inner_v);

      if (p == 1) begin
        // A long track of full-pt neutrals at zero distance drives the sum
        // into saturation and keeps it there until the last beat.
        for (int k = 0; k < 300; k++) begin
          send_candidate(make_cand(-700, 1200, -700, 1200, 65535, ChargeNeutral,
                                   k == 299));
        end
      end
      if (p == 4) begin
        // The receiver holds off while short tracks keep coming, so the
        // result register fills and the block must stall its input.
        hold_left = 300;
        for (int k = 0; k < 30; k++) begin
          run_track($urandom_range(1, 2), 70);
        end
      end

      phase_start = beats_sent;
      while (beats_sent - phase_start < PhaseBeats) begin
        run_track(random_track_len(), 70);
      end
      wait_idle();
    end

    // Final drain, bounded so that sums still owed show up as failures.
    in_valid = 1'b0;
    guard = 0;
    while (tracker.outstanding() > 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (DrainCycles) @(negedge clk);

    $display("Run covered %0d candidate beats in %0d tracks with %0d radius writes.",
             beats_sent, tracker.tracks, radius_writes);
    $display("Checked %0d sums (%0d saturated), %0d mismatches, %0d sums still owed.",
             tracker.checked, tracker.saturated_seen, tracker.mismatches,
             tracker.outstanding());
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ncis_pkg.sv
hdl/ncis_dist.sv
hdl/ncis_accum.sv
hdl/neutral_cone_isolation_sum.sv
tb/neutral_cone_isolation_sum_test.sv
